// ===== rtl/s20_pkg.sv =====
// s20_pkg: shared constants, types and helpers for the salsa20 stream cipher core
// no dependencies; imported by s20_qround, s20_block and salsa20_stream_cipher_core
`default_nettype none

package s20_pkg;

  // round configuration
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RND_W         = $clog2(HALF_ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(HALF_ROUNDS - 1);

  // block geometry
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned POS_W     = $clog2(NUM_SLOTS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_SLOTS - 1);

  // configuration registers
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER = CFG_IDX_W'(4);

  // chunk fields
  localparam int unsigned CHUNK_W    = 64;
  localparam int unsigned BYTES_W    = 4;
  localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(8);

  // rotation amounts of the quarter round
  localparam int unsigned ROT_B = 7;
  localparam int unsigned ROT_C = 9;
  localparam int unsigned ROT_D = 13;
  localparam int unsigned ROT_A = 18;

  typedef logic [31:0] word_t;
  typedef logic [NUM_WORDS-1:0][31:0] blk_t;
  typedef logic [NUM_SLOTS-1:0][63:0] slots_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  // rotate left by a constant amount
  function automatic word_t rotl(input word_t v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // word index of quarter-round operand pos (a=0..d=3) of lane in a column round
  function automatic logic [3:0] col_idx(input int unsigned lane, input int unsigned pos);
    return 4'((5 * lane + 4 * pos) & 15);
  endfunction

  // word index of quarter-round operand pos of lane in a row round
  function automatic logic [3:0] row_idx(input int unsigned lane, input int unsigned pos);
    return 4'(4 * lane + ((lane + pos) & 3));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/salsa20_stream_cipher_core.sv =====
// salsa20_stream_cipher_core: top level, config registers, block counter, keystream store
// depends on s20_pkg and s20_block (which uses s20_qround)
//
//   channel   | direction | signals                                          | handshake
//   ----------+-----------+--------------------------------------------------+-------------
//   in        | input     | message_chunk_i, chunk_bytes_i, end_of_message_i | valid/ready
//   out       | output    | cipher_chunk_o, out_bytes_o, out_last_o          | valid/ready
//   cfg       | input     | cfg_index_i, cfg_wdata_i                         | cfg_we_i only
//
// an item with keystream held or with no bytes is taken and its result registered at once
// an item that needs a fresh block waits, with no new item taken, for the round lanes;
// needed after reset, a last item or a counter write, then every eight chunks with bytes
// reset clears control, config and counter at once; the keystream store needs no clearing
// a new item is taken only while the output register is empty or being emptied
`default_nettype none

module salsa20_stream_cipher_core
  import s20_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CHUNK_W-1:0]   message_chunk_i,
  input  logic [BYTES_W-1:0]   chunk_bytes_i,
  input  logic                 end_of_message_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHUNK_W-1:0]   cipher_chunk_o,
  output logic [BYTES_W-1:0]   out_bytes_o,
  output logic                 out_last_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_GEN  = 1'b1;

  logic               st_q;
  logic [63:0]        cfg_q [NUM_REGS];
  logic [63:0]        counter_q;
  logic [POS_W-1:0]   pos_q;
  logic               held_q;
  logic [63:0]        ks_mem_q [NUM_SLOTS];

  logic [CHUNK_W-1:0] hold_msg_q;
  logic [BYTES_W-1:0] hold_nb_q;
  logic               hold_last_q;

  logic               out_valid_q;
  logic [CHUNK_W-1:0] out_data_q;
  logic [BYTES_W-1:0] out_nb_q;
  logic               out_last_q;

  logic               out_free;
  logic               in_acc;
  logic [BYTES_W-1:0] in_nb;
  logic               need_blk;
  logic               blk_start;
  logic               blk_done;
  blk_t               blk_ks;
  slots_t             blk_slots;
  slots_t             init_slots;
  logic               load_out;

  logic [CHUNK_W-1:0] sel_msg;
  logic [BYTES_W-1:0] sel_nb;
  logic               sel_last;
  logic [63:0]        sel_ks;
  logic [POS_W-1:0]   sel_pos;
  logic [CHUNK_W-1:0] mask;
  logic [CHUNK_W-1:0] result;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // clamp byte count, decide whether a new block is needed
  assign in_nb     = (chunk_bytes_i > MAX_BYTES) ? MAX_BYTES : chunk_bytes_i;
  assign need_blk  = (in_nb != '0) && !held_q;
  assign blk_start = in_acc && need_blk;

  // block input words: config pairs, counter in the counter slot
  always_comb begin
    for (int unsigned j = 0; j < NUM_SLOTS; j++) begin
      init_slots[j] = (CFG_IDX_W'(j) == REG_COUNTER) ? counter_q : cfg_q[j];
    end
  end

  s20_block u_block (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blk_start),
    .init_i  (blk_t'(init_slots)),
    .done_o  (blk_done),
    .ks_o    (blk_ks)
  );

  assign blk_slots = slots_t'(blk_ks);

  // item and keystream source: fresh block uses slot zero of the new block
  always_comb begin
    if (st_q == ST_GEN) begin
      sel_msg  = hold_msg_q;
      sel_nb   = hold_nb_q;
      sel_last = hold_last_q;
      sel_ks   = blk_slots[0];
      sel_pos  = '0;
    end else begin
      sel_msg  = message_chunk_i;
      sel_nb   = in_nb;
      sel_last = end_of_message_i;
      sel_ks   = ks_mem_q[pos_q];
      sel_pos  = pos_q;
    end
  end

  // byte mask and result
  always_comb begin
    for (int unsigned k = 0; k < NUM_SLOTS; k++) begin
      mask[8*k +: 8] = (BYTES_W'(k) < sel_nb) ? 8'hFF : 8'h00;
    end
    result = (sel_msg ^ sel_ks) & mask;
  end

  assign load_out = (in_acc && !need_blk) || ((st_q == ST_GEN) && blk_done);

  // control, config registers and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      counter_q   <= '0;
      pos_q       <= '0;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int unsigned j = 0; j < NUM_REGS; j++) begin
        cfg_q[j] <= '0;
      end
    end else begin
      // configuration writes, out of range ignored
      if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
        cfg_q[cfg_index_i[POS_W-1:0]] <= cfg_wdata_i;
        if (cfg_index_i == REG_COUNTER) begin
          counter_q <= cfg_wdata_i;
          held_q    <= 1'b0;
          pos_q     <= '0;
        end
      end

      unique case (st_q)
        ST_IDLE: begin
          if (blk_start) begin
            st_q <= ST_GEN;
          end
        end
        ST_GEN: begin
          if (blk_done) begin
            st_q      <= ST_IDLE;
            counter_q <= counter_q + 64'd1;
          end
        end
        default: st_q <= ST_IDLE;
      endcase

      // slot bookkeeping for every item that produces a result here
      if (load_out) begin
        if (sel_nb != '0) begin
          if (sel_pos == POS_LAST) begin
            held_q <= 1'b0;
            pos_q  <= '0;
          end else begin
            held_q <= 1'b1;
            pos_q  <= sel_pos + POS_W'(1);
          end
        end
        if (sel_last) begin
          held_q <= 1'b0;
          pos_q  <= '0;
        end
      end

      // output register
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: held item, keystream store, output data
  always_ff @(posedge clk_i) begin
    if (blk_start) begin
      hold_msg_q  <= message_chunk_i;
      hold_nb_q   <= in_nb;
      hold_last_q <= end_of_message_i;
    end
    if ((st_q == ST_GEN) && blk_done) begin
      for (int unsigned j = 0; j < NUM_SLOTS; j++) begin
        ks_mem_q[j] <= blk_slots[j];
      end
    end
    if (load_out) begin
      out_data_q <= result;
      out_nb_q   <= sel_nb;
      out_last_q <= sel_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cipher_chunk_o = out_data_q;
  assign out_bytes_o    = out_nb_q;
  assign out_last_o     = out_last_q;

`ifndef SYNTHESIS
  // the block generator only finishes while an item waits for it
  a_done_in_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_done |-> (st_q == ST_GEN))
    else $error("block finished outside generation");

  // each finished block steps the counter by one
  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_done && !cfg_we_i) |=> (counter_q == $past(counter_q) + 64'd1))
    else $error("block counter did not step");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load_out)
    else $error("output register overwritten");

  // the slot position stays at zero while no keystream is held
  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (pos_q == '0))
    else $error("slot position set without keystream");
`endif

endmodule

`default_nettype wire

// ===== rtl/s20_qround.sv =====
// s20_qround: one quarter-round lane, combinational
// depends on s20_pkg for word type, rotation amounts and qr_t
`default_nettype none

module s20_qround
  import s20_pkg::*;
(
  input  qr_t in_i,
  output qr_t out_o
);

  word_t b1;
  word_t c1;
  word_t d1;
  word_t a1;

  // four dependent add-rotate-xor steps
  always_comb begin
    b1 = in_i.b ^ rotl(in_i.a + in_i.d, ROT_B);
    c1 = in_i.c ^ rotl(b1 + in_i.a, ROT_C);
    d1 = in_i.d ^ rotl(c1 + b1, ROT_D);
    a1 = in_i.a ^ rotl(d1 + c1, ROT_A);
  end

  assign out_o = '{a: a1, b: b1, c: c1, d: d1};

endmodule

`default_nettype wire

// ===== rtl/s20_block.sv =====
// s20_block: keystream block generator, four quarter-round lanes over the 16-word state
// depends on s20_pkg and s20_qround; one half round per cycle, then the final add
`default_nettype none

module s20_block
  import s20_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  blk_t init_i,
  output logic done_o,
  output blk_t ks_o
);

  blk_t             w_q;
  blk_t             w_d;
  blk_t             init_q;
  blk_t             ks_q;
  logic [RND_W-1:0] cnt_q;
  logic             run_q;
  logic             add_q;
  logic             done_q;
  logic             row_phase;
  qr_t              lane_in  [NUM_LANES];
  qr_t              lane_out [NUM_LANES];

  // even half rounds work on columns, odd ones on rows
  assign row_phase = cnt_q[0];

  // lane operand selection and the lanes themselves
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam logic [3:0] CA = col_idx(l, 0);
    localparam logic [3:0] CB = col_idx(l, 1);
    localparam logic [3:0] CC = col_idx(l, 2);
    localparam logic [3:0] CD = col_idx(l, 3);
    localparam logic [3:0] RA = row_idx(l, 0);
    localparam logic [3:0] RB = row_idx(l, 1);
    localparam logic [3:0] RC = row_idx(l, 2);
    localparam logic [3:0] RD = row_idx(l, 3);

    assign lane_in[l].a = row_phase ? w_q[RA] : w_q[CA];
    assign lane_in[l].b = row_phase ? w_q[RB] : w_q[CB];
    assign lane_in[l].c = row_phase ? w_q[RC] : w_q[CC];
    assign lane_in[l].d = row_phase ? w_q[RD] : w_q[CD];

    s20_qround u_qround (
      .in_i  (lane_in[l]),
      .out_o (lane_out[l])
    );
  end

  // merge lane results back into the state
  always_comb begin
    w_d = w_q;
    for (int unsigned l = 0; l < NUM_LANES; l++) begin
      if (row_phase) begin
        w_d[row_idx(l, 0)] = lane_out[l].a;
        w_d[row_idx(l, 1)] = lane_out[l].b;
        w_d[row_idx(l, 2)] = lane_out[l].c;
        w_d[row_idx(l, 3)] = lane_out[l].d;
      end else begin
        w_d[col_idx(l, 0)] = lane_out[l].a;
        w_d[col_idx(l, 1)] = lane_out[l].b;
        w_d[col_idx(l, 2)] = lane_out[l].c;
        w_d[col_idx(l, 3)] = lane_out[l].d;
      end
    end
  end

  // round sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= add_q;
      add_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + RND_W'(1);
        if (cnt_q == RND_LAST) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
        end
      end
    end
  end

  // state, input copy and final feed-forward add
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q    <= init_i;
      init_q <= init_i;
    end else if (run_q) begin
      w_q <= w_d;
    end
    if (add_q) begin
      for (int unsigned i = 0; i < NUM_WORDS; i++) begin
        ks_q[i] <= w_q[i] + init_q[i];
      end
    end
  end

  assign done_o = done_q;
  assign ks_o   = ks_q;

endmodule

`default_nettype wire
